FILE: design/hruv_pkg.sv
// Package for the root URL validator: payload structs, phase and segment codes,
// character class helpers. No dependencies.
package hruv_pkg;

  localparam int unsigned UrlCapacity = 256;
  localparam int unsigned HostLimit   = 128;
  localparam int unsigned LabelLimit  = 63;
  localparam int unsigned PathLimit   = 96;
  localparam int unsigned PortMax     = 65535;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        url_ok;
    logic        is_https;
    logic [15:0] port_number;
    logic [6:0]  host_length;
    logic [6:0]  path_length;
  } out_item_t;

  // classified byte handed from the front end to the parser
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_byte;
    logic       is_digit;
    logic       is_alnum;
    logic       is_hex;
    logic [3:0] hex_val;
  } cls_item_t;

  typedef enum logic [1:0] {
    PH_SCHEME = 2'd0,
    PH_HOST   = 2'd1,
    PH_PORT   = 2'd2,
    PH_PATH   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    SEG_EMPTY = 2'd0,
    SEG_DOT1  = 2'd1,
    SEG_DOT2  = 2'd2,
    SEG_OTHER = 2'd3
  } seg_e;

  function automatic logic is_digit_f(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha_f(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic [4:0] hex_f(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if ((c >= 8'h30) && (c <= 8'h39)) v = 5'(c - 8'h30);
    else if ((c >= 8'h61) && (c <= 8'h66)) v = 5'(c - 8'h57);
    else if ((c >= 8'h41) && (c <= 8'h46)) v = 5'(c - 8'h37);
    return v;
  endfunction

endpackage

FILE: design/hruv_front.sv
// Front end: accepts bytes, classifies them, holds them in a 2-entry queue.
// Depends on hruv_pkg.
module hruv_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hruv_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_pop_i,
  output hruv_pkg::cls_item_t q_data_o
);
  hruv_pkg::cls_item_t mem_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  hruv_pkg::cls_item_t cls;
  logic [4:0] hx;
  logic push, pop;

  always_comb begin
    hx            = hruv_pkg::hex_f(in_data_i.char_code);
    cls.char_code = in_data_i.char_code;
    cls.last_byte = in_data_i.last_byte;
    cls.is_digit  = hruv_pkg::is_digit_f(in_data_i.char_code);
    cls.is_alnum  = cls.is_digit || hruv_pkg::is_alpha_f(in_data_i.char_code);
    cls.is_hex    = !hx[4];
    cls.hex_val   = hx[3:0];
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_pop_i && q_valid_o;
  assign q_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1)) else $error("count slip");
endmodule

FILE: design/hruv_back.sv
// Back end: URL parser state machine and registered result stage.
// Depends on hruv_pkg.
module hruv_back #(
  parameter int unsigned UrlCapacity = hruv_pkg::UrlCapacity,
  parameter int unsigned HostLimit   = hruv_pkg::HostLimit,
  parameter int unsigned LabelLimit  = hruv_pkg::LabelLimit,
  parameter int unsigned PathLimit   = hruv_pkg::PathLimit
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  hruv_pkg::cls_item_t q_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hruv_pkg::out_item_t out_data_o
);
  localparam int TW = $clog2(UrlCapacity + 1);
  localparam int HW = $clog2(HostLimit + 1);
  localparam int PW = $clog2(PathLimit + 1);
  localparam int LW = 7;

  hruv_pkg::phase_e phase_q, phase_d;
  hruv_pkg::seg_e   seg_q, seg_d;
  logic [3:0]  pos_q, pos_d;
  logic [TW-1:0] tot_q, tot_d;
  logic [HW-1:0] host_q, host_d;
  logic [LW-1:0] lab_q, lab_d;
  logic [7:0]  prev_q;
  logic [16:0] port_q, port_d;
  logic [2:0]  pdig_q, pdig_d;
  logic [PW-1:0] path_q, path_d;
  logic [1:0]  pct_q, pct_d;
  logic [3:0]  hn_q, hn_d;
  logic        https_q, https_d, fault_q, fault_d;
  logic        ov_q;
  hruv_pkg::out_item_t od_q, res;
  logic        take, fin;
  logic [7:0]  c, want, dec;
  logic [20:0] pmul;
  logic [PW-1:0] plen;
  logic        pgood;

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign q_pop_o     = q_valid_i && !(ov_q && out_stall_i);
  assign take        = q_pop_o;
  assign c           = q_data_i.char_code;

  always_comb begin
    unique case (pos_q)
      4'd0: want = 8'h68; 4'd1: want = 8'h74; 4'd2: want = 8'h74; 4'd3: want = 8'h70;
      4'd5: want = https_q ? 8'h3a : 8'h2f;
      4'd6: want = 8'h2f;
      4'd7: want = 8'h2f;
      default: want = 8'h00;
    endcase
  end

  always_comb begin
    phase_d = phase_q; seg_d = seg_q; pos_d = pos_q; host_d = host_q; lab_d = lab_q;
    port_d = port_q; pdig_d = pdig_q; path_d = path_q; pct_d = pct_q; hn_d = hn_q;
    https_d = https_q; fault_d = fault_q;
    pmul = 21'(port_q) * 21'd10 + 21'(c - 8'h30);
    dec = {hn_q, q_data_i.hex_val};
    tot_d = (tot_q < TW'(UrlCapacity)) ? TW'(tot_q + 1'b1) : tot_q;
    if (tot_d >= TW'(UrlCapacity)) fault_d = 1'b1;
    pgood = (pdig_q >= 3'd1) && (pdig_q <= 3'd5) && (port_q >= 17'd1) &&
            (port_q <= 17'(hruv_pkg::PortMax));
    if (!fault_d) begin
      unique case (phase_q)
        hruv_pkg::PH_SCHEME: begin
          if (pos_q == 4'd4 && !(c == 8'h73 || c == 8'h3a)) fault_d = 1'b1;
          else if (pos_q != 4'd4 && c != want) fault_d = 1'b1;
          else begin
            if (pos_q == 4'd4) https_d = (c == 8'h73);
            pos_d = pos_q + 4'd1;
            if (pos_d >= (https_d ? 4'd8 : 4'd7)) phase_d = hruv_pkg::PH_HOST;
          end
        end
        hruv_pkg::PH_HOST: begin
          if (c == 8'h3a) begin
            if (host_q == '0 || lab_q == '0 || prev_q == 8'h2d) fault_d = 1'b1;
            else phase_d = hruv_pkg::PH_PORT;
          end else begin
            if (host_q < HW'(HostLimit)) host_d = HW'(host_q + 1'b1);
            if (host_d >= HW'(HostLimit)) fault_d = 1'b1;
            else if (c == 8'h2e) begin
              if (lab_q == '0 || prev_q == 8'h2d) fault_d = 1'b1;
              lab_d = '0;
            end else if (q_data_i.is_alnum || c == 8'h2d) begin
              if (lab_q == '0 && c == 8'h2d) fault_d = 1'b1;
              else begin
                if (lab_q <= LW'(LabelLimit)) lab_d = LW'(lab_q + 1'b1);
                if (lab_d > LW'(LabelLimit)) fault_d = 1'b1;
              end
            end else fault_d = 1'b1;
          end
        end
        hruv_pkg::PH_PORT: begin
          if (c == 8'h2f) begin
            if (!pgood) fault_d = 1'b1;
            else begin
              phase_d = hruv_pkg::PH_PATH; path_d = PW'(1); seg_d = hruv_pkg::SEG_EMPTY;
            end
          end else if (!q_data_i.is_digit) fault_d = 1'b1;
          else begin
            if (pdig_q < 3'd6) pdig_d = pdig_q + 3'd1;
            if (pdig_d > 3'd5) fault_d = 1'b1;
            else if (pmul > 21'(hruv_pkg::PortMax)) begin
              port_d = 17'(hruv_pkg::PortMax + 1); fault_d = 1'b1;
            end else port_d = pmul[16:0];
          end
        end
        hruv_pkg::PH_PATH: begin
          if (path_q < PW'(PathLimit)) path_d = PW'(path_q + 1'b1);
          if (path_d >= PW'(PathLimit)) fault_d = 1'b1;
          else if (pct_q != 2'd0) begin
            if (!q_data_i.is_hex) fault_d = 1'b1;
            else if (pct_q == 2'd1) begin
              hn_d = q_data_i.hex_val; pct_d = 2'd2;
            end else begin
              if (dec == 8'h2e || dec == 8'h2f || dec == 8'h5c || dec == 8'h00)
                fault_d = 1'b1;
              pct_d = 2'd0;
            end
          end else if (c == 8'h2f) begin
            if (seg_q != hruv_pkg::SEG_OTHER) fault_d = 1'b1;
            seg_d = hruv_pkg::SEG_EMPTY;
          end else if (c == 8'h2e) begin
            unique case (seg_q)
              hruv_pkg::SEG_EMPTY: seg_d = hruv_pkg::SEG_DOT1;
              hruv_pkg::SEG_DOT1:  seg_d = hruv_pkg::SEG_DOT2;
              default:             seg_d = hruv_pkg::SEG_OTHER;
            endcase
          end else if (c == 8'h25) begin
            seg_d = hruv_pkg::SEG_OTHER; pct_d = 2'd1;
          end else if (q_data_i.is_alnum || c == 8'h2d || c == 8'h5f || c == 8'h7e) begin
            seg_d = hruv_pkg::SEG_OTHER;
          end else fault_d = 1'b1;
        end
        default: fault_d = 1'b1;
      endcase
    end
    // end-of-URL checks
    fin = fault_d;
    plen = '0;
    if (!fault_d) begin
      unique case (phase_d)
        hruv_pkg::PH_PORT: fin = !((pdig_d >= 3'd1) && (pdig_d <= 3'd5) &&
                                   (port_d >= 17'd1) && (port_d <= 17'(hruv_pkg::PortMax)));
        hruv_pkg::PH_PATH: begin
          fin = (pct_d != 2'd0) || seg_d == hruv_pkg::SEG_DOT1 || seg_d == hruv_pkg::SEG_DOT2;
          plen = (path_d != '0 && c == 8'h2f) ? PW'(path_d - 1'b1) : path_d;
        end
        default: fin = 1'b1;
      endcase
    end
    res.url_ok      = !fin;
    res.is_https    = !fin && https_d;
    res.port_number = fin ? 16'd0 : port_d[15:0];
    res.host_length = fin ? 7'd0 : 7'(host_d);
    res.path_length = fin ? 7'd0 : 7'(plen);
  end

  always_ff @(posedge clk_i) begin
    if (take && q_data_i.last_byte) od_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      if (take && q_data_i.last_byte) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hruv_pkg::PH_SCHEME; seg_q <= hruv_pkg::SEG_EMPTY; pos_q <= '0;
      tot_q <= '0; host_q <= '0; lab_q <= '0; prev_q <= '0; port_q <= '0; pdig_q <= '0;
      path_q <= '0; pct_q <= '0; hn_q <= '0; https_q <= 1'b0; fault_q <= 1'b0;
    end else if (take) begin
      if (q_data_i.last_byte) begin
        phase_q <= hruv_pkg::PH_SCHEME; seg_q <= hruv_pkg::SEG_EMPTY; pos_q <= '0;
        tot_q <= '0; host_q <= '0; lab_q <= '0; prev_q <= '0; port_q <= '0; pdig_q <= '0;
        path_q <= '0; pct_q <= '0; hn_q <= '0; https_q <= 1'b0; fault_q <= 1'b0;
      end else begin
        phase_q <= phase_d; seg_q <= seg_d; pos_q <= pos_d; tot_q <= tot_d;
        host_q <= host_d; lab_q <= lab_d; prev_q <= c; port_q <= port_d;
        pdig_q <= pdig_d; path_q <= path_d; pct_q <= pct_d; hn_q <= hn_d;
        https_q <= https_d; fault_q <= fault_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q && $stable(od_q)) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.url_ok) |-> (out_data_o.port_number == 16'd0))
    else $error("invalid result carries port");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != hruv_pkg::PH_SCHEME) |-> (pos_q >= 4'd7)) else $error("phase skip");
endmodule

FILE: design/http_root_url_validator_top.sv
// Root URL validator: one byte per transfer, one result per URL on the final byte.
// Takes a byte each clock unless stalled; the verdict leaves a registered result
// stage in the cycle after the parser takes the final byte. A 2-entry classified
// byte queue separates intake from the parser so each side stalls on its own.
// Depends on hruv_pkg, hruv_front, hruv_back.
module http_root_url_validator_top #(
  parameter int unsigned UrlCapacity = hruv_pkg::UrlCapacity,
  parameter int unsigned HostLimit   = hruv_pkg::HostLimit,
  parameter int unsigned LabelLimit  = hruv_pkg::LabelLimit,
  parameter int unsigned PathLimit   = hruv_pkg::PathLimit
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hruv_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hruv_pkg::out_item_t out_data_o
);
  logic q_valid, q_pop;
  hruv_pkg::cls_item_t q_data;

  hruv_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  hruv_back #(
    .UrlCapacity(UrlCapacity), .HostLimit(HostLimit),
    .LabelLimit(LabelLimit), .PathLimit(PathLimit)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
